### rtl/btc_pkg.sv
`timescale 1ns / 1ps

package btc_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 32;
    localparam int CFG_IW  = 3;

    // Internal datapath widths, sized from the input ranges
    localparam int DT_W    = RAW_W + 1;          // D2 - (C5 << 8)
    localparam int PROD_W  = CAL_W + 1 + DT_W;   // signed coeff * dT
    localparam int OFF_W   = 36;                 // (C2 << 17) + (C4*dT >> 6)
    localparam int SENS_W  = 35;                 // (C1 << 16) + (C3*dT >> 7)
    localparam int SLO_W   = 17;                 // low, unsigned slice of SENS
    localparam int SHI_W   = SENS_W - SLO_W;     // high, signed slice of SENS
    localparam int PPLO_W  = RAW_W + SLO_W;
    localparam int PPHI_W  = RAW_W + 1 + SHI_W;
    localparam int FULL_W  = 60;                 // D1 * SENS
    localparam int DIFF_W  = FULL_W - 21 + 1;    // (D1*SENS >> 21) - OFF
    localparam int PQ_W    = DIFF_W - 15;        // pressure before extension

    // Compensation constants
    localparam int TEMP_BASE   = 2000;
    localparam int C5_SHIFT    = 8;
    localparam int TEMP_SHIFT  = 23;
    localparam int OFF_C_SHIFT = 17;
    localparam int OFF_SHIFT   = 6;
    localparam int SENS_C_SHIFT = 16;
    localparam int SENS_SHIFT  = 7;
    localparam int PROD_SHIFT  = 21;
    localparam int PRES_SHIFT  = 15;

    // Calibration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CAL_SENS     = 3'd0,
        CAL_OFF      = 3'd1,
        CAL_TCS      = 3'd2,
        CAL_TCO      = 3'd3,
        CAL_TREF     = 3'd4,
        CAL_TEMPSENS = 3'd5
    } cal_index_t;

endpackage

### rtl/baro_temp_compensation.sv
`timescale 1ns / 1ps

// First-order barometric compensation. Each input word carries one raw
// pressure (D1) and one raw temperature (D2) conversion; each output word
// carries the compensated temperature in hundredths of a degree and the
// pressure in pascals. The six calibration words reset to zero and are
// written through the cfg port; the user must do so only while no word is
// in flight, which the block does not enforce. The datapath is a six-stage
// pipeline (difference, coefficient products, offset/sensitivity, split
// D1*SENS partial products, product sum, final shift) that takes one word
// per cycle while in_stall is low. A stall on the output holds the pipeline
// only as far back as needed, since empty stages keep filling. The pressure
// result always fits signed 32 bits for these input widths: a sign extension.
module baro_temp_compensation
    import btc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_write_en,
    input  logic [CFG_IW-1:0]          cfg_index,
    input  logic [CAL_W-1:0]           cfg_data,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [RAW_W-1:0]           raw_pressure,
    input  logic [RAW_W-1:0]           raw_temperature,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [TEMP_W-1:0]   temperature_centideg,
    output logic signed [PRES_W-1:0]   pressure_pa
);

    // Calibration registers
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cal_index_t'(cfg_index))
                CAL_SENS:     c1_reg <= cfg_data;
                CAL_OFF:      c2_reg <= cfg_data;
                CAL_TCS:      c3_reg <= cfg_data;
                CAL_TCO:      c4_reg <= cfg_data;
                CAL_TREF:     c5_reg <= cfg_data;
                CAL_TEMPSENS: c6_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Stage valids and per-stage advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !v6_reg || !out_stall;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // Stage 1: dT = D2 - (C5 << 8)
    logic        [RAW_W-1:0]  d1_s1_reg;
    logic signed [DT_W-1:0]   dt_next, dt_reg;

    assign dt_next = $signed({1'b0, raw_temperature})
                   - $signed({1'b0, c5_reg, {C5_SHIFT{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            d1_s1_reg <= raw_pressure;
            dt_reg    <= dt_next;
        end
    end

    // Stage 2: the three coefficient products
    logic        [RAW_W-1:0]  d1_s2_reg;
    logic signed [PROD_W-1:0] p6_next, p4_next, p3_next;
    logic signed [PROD_W-1:0] p6_reg, p4_reg, p3_reg;

    assign p6_next = PROD_W'($signed({1'b0, c6_reg})) * PROD_W'(dt_reg);
    assign p4_next = PROD_W'($signed({1'b0, c4_reg})) * PROD_W'(dt_reg);
    assign p3_next = PROD_W'($signed({1'b0, c3_reg})) * PROD_W'(dt_reg);

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            d1_s2_reg <= d1_s1_reg;
            p6_reg    <= p6_next;
            p4_reg    <= p4_next;
            p3_reg    <= p3_next;
        end
    end

    // Stage 3: temperature, OFF and SENS
    logic        [RAW_W-1:0]  d1_s3_reg;
    logic signed [TEMP_W-1:0] temp_next, temp_s3_reg;
    logic signed [OFF_W-1:0]  off_next, off_s3_reg;
    logic signed [SENS_W-1:0] sens_next, sens_reg;

    assign temp_next = TEMP_W'(p6_reg >>> TEMP_SHIFT) + TEMP_W'(TEMP_BASE);
    assign off_next  = OFF_W'($signed({1'b0, c2_reg, {OFF_C_SHIFT{1'b0}}}))
                     + OFF_W'(p4_reg >>> OFF_SHIFT);
    assign sens_next = SENS_W'($signed({1'b0, c1_reg, {SENS_C_SHIFT{1'b0}}}))
                     + SENS_W'(p3_reg >>> SENS_SHIFT);

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            d1_s3_reg   <= d1_s2_reg;
            temp_s3_reg <= temp_next;
            off_s3_reg  <= off_next;
            sens_reg    <= sens_next;
        end
    end

    // Stage 4: D1 * SENS as two partial products
    logic                     [PPLO_W-1:0] pp_lo_next, pp_lo_reg;
    logic signed              [PPHI_W-1:0] pp_hi_next, pp_hi_reg;
    logic signed              [SHI_W-1:0]  sens_hi;
    logic                     [SLO_W-1:0]  sens_lo;
    logic signed [TEMP_W-1:0] temp_s4_reg;
    logic signed [OFF_W-1:0]  off_s4_reg;

    assign sens_lo    = sens_reg[SLO_W-1:0];
    assign sens_hi    = sens_reg[SENS_W-1:SLO_W];
    assign pp_lo_next = PPLO_W'(d1_s3_reg) * PPLO_W'(sens_lo);
    assign pp_hi_next = PPHI_W'($signed({1'b0, d1_s3_reg})) * PPHI_W'(sens_hi);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            temp_s4_reg <= temp_s3_reg;
            off_s4_reg  <= off_s3_reg;
        end
    end

    // Stage 5: sum the partial products
    logic signed [FULL_W-1:0] full_next, full_reg;
    logic signed [TEMP_W-1:0] temp_s5_reg;
    logic signed [OFF_W-1:0]  off_s5_reg;

    assign full_next = (FULL_W'(pp_hi_reg) <<< SLO_W)
                     + $signed({{(FULL_W-PPLO_W){1'b0}}, pp_lo_reg});

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            full_reg    <= full_next;
            temp_s5_reg <= temp_s4_reg;
            off_s5_reg  <= off_s4_reg;
        end
    end

    // Stage 6: P = ((D1*SENS >> 21) - OFF) >> 15, output register
    logic signed [DIFF_W-1:0] diff;
    logic signed [PQ_W-1:0]   pq;
    logic signed [PRES_W-1:0] pres_next, pres_reg;
    logic signed [TEMP_W-1:0] temp_out_reg;

    assign diff      = DIFF_W'(full_reg >>> PROD_SHIFT) - DIFF_W'(off_s5_reg);
    assign pq        = PQ_W'(diff >>> PRES_SHIFT);
    // pq is narrower than 32 bits, so the clamp is a sign extension
    assign pres_next = PRES_W'(pq);

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            pres_reg     <= pres_next;
            temp_out_reg <= temp_s5_reg;
        end
    end

    assign out_valid            = v6_reg;
    assign pressure_pa          = pres_reg;
    assign temperature_centideg = temp_out_reg;

    // Checks
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> !in_stall)
        else $error("input stalled with an empty first stage");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (temperature_centideg >= -19'sd129070)
                   && (temperature_centideg <= 19'sd133070))
        else $error("temperature outside its range");

    a_pres_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pressure_pa[PRES_W-1:PQ_W-1] == '0)
                   || (pressure_pa[PRES_W-1:PQ_W-1] == '1))
        else $error("pressure exceeded its internal width");

    a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v6_reg) |-> $past(v5_reg))
        else $error("output valid without a word in the stage before");

endmodule
